/* hw/rtl/stack_without_duplicates_defines.svh */
// Assertion macros used by the checker of the unique-insert stack.
`ifndef STACK_WITHOUT_DUPLICATES_DEFINES_SVH
`define STACK_WITHOUT_DUPLICATES_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during rst.
`define SWD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during rst.
`define SWD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/swd_pkg.sv */
// Shared constants, codes and types of the unique-insert stack.
`default_nettype none

package swd_pkg;

  localparam int DEPTH     = 128;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CNT_OUT_W = 8;
  localparam int STATUS_W  = 3;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;   // capture the match flag against the incoming word
    logic push;  // shift toward the bottom, new word enters at the top
    logic pop;   // shift toward the top
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/swd_cell.sv */
// One stack cell: holds an entry, matches it and shifts with its neighbors.
`default_nettype none

module swd_cell import swd_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic              occupied,
  input  wire logic [DATA_W-1:0] cmp_value,
  input  wire logic [DATA_W-1:0] upper_entry,
  input  wire logic [DATA_W-1:0] lower_entry,
  output logic      [DATA_W-1:0] entry,
  output logic                   hit
);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit <= occupied && (entry == cmp_value);
    end
    if (ctl.push) begin
      entry <= upper_entry;
    end else if (ctl.pop) begin
      entry <= lower_entry;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stack_without_duplicates.sv */
// Top level: bounded LIFO stack that refuses duplicate pushes.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   item     | item_valid / item_stall    | action, value
//   result   | result_valid / result_stall| status, popped_value, count
//
// Each item: at the accept edge every cell matches its entry against the
// incoming word; in the S_CMP state the OR of the match flags picks the
// outcome, the chain shifts and the result register loads.
// A stalled result holds the commit cycle until the result register frees.
// Reset clears the state, the entry count and result_valid; cell contents need no clearing.
`default_nettype none

module stack_without_duplicates import swd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic                     action,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic        [STATUS_W-1:0]    status,
  output logic signed [DATA_W-1:0]      popped_value,
  output logic        [CNT_OUT_W-1:0]   count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CMP  = 2'b10
  } state_t;

  state_t            state;
  logic              action_q;
  logic [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  entry_count_next;

  logic [DATA_W-1:0] cell_entry [DEPTH];
  logic [DEPTH-1:0]  cell_hit;
  cell_ctl_t         ctl;

  logic              take;
  logic              commit;
  logic              do_push;
  logic              do_pop;
  status_t           status_next;
  logic [DATA_W-1:0] popped_next;

  assign item_stall = (state != S_IDLE);
  assign take       = item_valid && !item_stall;
  assign commit     = (state == S_CMP) && (!result_valid || !result_stall);

  // Decide from the registered match flags.
  always_comb begin
    do_push          = 1'b0;
    do_pop           = 1'b0;
    status_next      = ST_PUSHED;
    popped_next      = '0;
    entry_count_next = entry_count;
    if (action_q == ACT_PUSH) begin
      if (|cell_hit) begin
        status_next = ST_DUPLICATE;
      end else if (entry_count == CNT_W'(DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        do_push          = 1'b1;
        status_next      = ST_PUSHED;
        entry_count_next = entry_count + CNT_W'(1);
      end
    end else begin
      if (entry_count == '0) begin
        status_next = ST_EMPTY;
      end else begin
        do_pop           = 1'b1;
        status_next      = ST_POPPED;
        popped_next      = cell_entry[0];
        entry_count_next = entry_count - CNT_W'(1);
      end
    end
  end

  always_comb begin
    ctl.cmp  = take;
    ctl.push = commit && do_push;
    ctl.pop  = commit && do_pop;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] upper;
    logic [DATA_W-1:0] lower;
    logic              occ;

    if (i == 0) begin : g_top
      assign upper = value_q;
    end else begin : g_mid
      assign upper = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign lower = cell_entry[i];
    end else begin : g_inner
      assign lower = cell_entry[i+1];
    end
    assign occ = (CNT_W'(i) < entry_count);

    swd_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .cmp_value   (value),
      .upper_entry (upper),
      .lower_entry (lower),
      .entry       (cell_entry[i]),
      .hit         (cell_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (commit) begin
        result_valid <= 1'b1;
        entry_count  <= entry_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      action_q <= action;
      value_q  <= value;
    end
    if (commit) begin
      status       <= status_next;
      popped_value <= popped_next;
      count        <= CNT_OUT_W'(entry_count_next);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/swd_checker.sv */
// Port-level checker for the unique-insert stack, bound to the top level.
`default_nettype none

`include "stack_without_duplicates_defines.svh"

module swd_checker import swd_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     item_valid,
  input wire logic                     item_stall,
  input wire logic                     result_valid,
  input wire logic                     result_stall,
  input wire logic [STATUS_W-1:0]      status,
  input wire logic signed [DATA_W-1:0] popped_value,
  input wire logic [CNT_OUT_W-1:0]     count
);

  `SWD_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(status) && $stable(popped_value) && $stable(count), "stalled result word changed")

  // One word in flight: the input side closes right after an accept.
  `SWD_ASSERT_NXT(a_busy_after_take, item_valid && !item_stall, item_stall, "input accepted while a word is in flight")

  `SWD_ASSERT_IMP(a_popped_zero, result_valid && (status != ST_POPPED), popped_value == '0, "popped_value nonzero outside a pop")

  `SWD_ASSERT_IMP(a_empty_count, result_valid && (status == ST_EMPTY), count == '0, "pop on empty with nonzero count")

  `SWD_ASSERT_IMP(a_full_count, result_valid && (status == ST_FULL), count == CNT_OUT_W'(DEPTH), "full reject below capacity")

endmodule

bind stack_without_duplicates swd_checker u_swd_checker (.*);

`default_nettype wire

/* tb/stack_without_duplicates_check.sv */
// Shadow stack that predicts every result of the unique-insert stack and checks it.
module stack_without_duplicates_check import swd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic                          action,
  input  logic signed [DATA_W-1:0]      value,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic        [STATUS_W-1:0]    status,
  input  logic signed [DATA_W-1:0]      popped_value,
  input  logic        [CNT_OUT_W-1:0]   count,
  output int unsigned                   mismatches,
  output int unsigned                   outstanding
);

  typedef struct packed {
    status_t                    st;
    logic signed [DATA_W-1:0]   val;
    logic        [CNT_OUT_W-1:0] cnt;
  } outcome_t;

  logic signed [DATA_W-1:0] shadow [DEPTH];
  int unsigned              held;
  outcome_t                 awaited [$];

  function automatic outcome_t apply_stack_op(logic act, logic signed [DATA_W-1:0] v);
    outcome_t o;
    bit       found;
    found = 1'b0;
    o.val = '0;
    if (act == ACT_PUSH) begin
      for (int i = 0; i < held; i++)
        if (shadow[i] == v) found = 1'b1;
      // a held match wins over a full stack
      if (found) begin
        o.st = ST_DUPLICATE;
      end else if (held >= DEPTH) begin
        o.st = ST_FULL;
      end else begin
        shadow[held] = v;
        held++;
        o.st = ST_PUSHED;
      end
    end else if (held == 0) begin
      o.st = ST_EMPTY;
    end else begin
      held--;
      o.val = shadow[held];
      o.st  = ST_POPPED;
    end
    o.cnt = held[CNT_OUT_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t exp_res;
    if (rst) begin
      held       = 0;
      mismatches = 0;
      awaited.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (awaited.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, got status %0d popped %0d count %0d",
                   $time, status, popped_value, count);
        end else begin
          exp_res = awaited.pop_front();
          if (status !== exp_res.st) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, exp_res.st, status);
          end
          if (popped_value !== exp_res.val) begin
            mismatches++;
            $display("%0t: popped_value expected %0d, got %0d",
                     $time, exp_res.val, popped_value);
          end
          if (count !== exp_res.cnt) begin
            mismatches++;
            $display("%0t: count expected %0d, got %0d", $time, exp_res.cnt, count);
          end
        end
      end
      if (item_valid && !item_stall)
        awaited.push_back(apply_stack_op(action, value));
    end
    outstanding <= awaited.size();
  end

endmodule

/* tb/stack_without_duplicates_tb.sv */
// Testbench top: clock, reset, push/pop stimulus and verdict for the unique-insert stack.
module stack_without_duplicates_tb;
  import swd_pkg::*;

  localparam int          RANDOM_ITEMS = 1500;
  localparam int unsigned LIMIT        = 200000;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        item_valid   = 1'b0;
  logic                        item_stall;
  logic                        action       = ACT_PUSH;
  logic signed [DATA_W-1:0]    value        = '0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  logic        [STATUS_W-1:0]  status;
  logic signed [DATA_W-1:0]    popped_value;
  logic        [CNT_OUT_W-1:0] count;

  int unsigned              mismatches;
  int unsigned              outstanding;
  int unsigned              cycles = 0;
  bit                       calm   = 1'b0;
  logic signed [DATA_W-1:0] recent [$];

  always #10 clk = ~clk;

  stack_without_duplicates dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .popped_value (popped_value),
    .count        (count)
  );

  stack_without_duplicates_check shadow_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .popped_value (popped_value),
    .count        (count),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || calm) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(0, 99) < 11);
  end

  task automatic send_word(input logic act, input logic signed [DATA_W-1:0] v);
    while (!calm && $urandom_range(0, 99) < 11) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    value      <= v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    // keep recent pushes around to provoke duplicates
    if (act == ACT_PUSH) begin
      recent.push_back(v);
      if (recent.size() > 32) void'(recent.pop_front());
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 40);
    if (r < 45) return $urandom;
    if (r < 70) return s - 20;
    if (r < 82) begin
      case (s % 5)
        0:       return {1'b1, {(DATA_W-1){1'b0}}};
        1:       return {1'b0, {(DATA_W-1){1'b1}}};
        2:       return '0;
        3:       return '1;
        default: return 1;
      endcase
    end
    if (recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
    return $urandom;
  endfunction

  initial begin
    int mode;
    int len;
    int push_pct;
    int done;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, extremes, duplicates, re-push of a popped value
    send_word(ACT_POP,  $urandom);
    send_word(ACT_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
    send_word(ACT_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
    send_word(ACT_PUSH, '0);
    send_word(ACT_PUSH, '1);
    send_word(ACT_PUSH, 1);
    send_word(ACT_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
    send_word(ACT_PUSH, '0);
    send_word(ACT_POP,  '1);
    send_word(ACT_PUSH, 1);
    send_word(ACT_POP,  $urandom);
    send_word(ACT_POP,  $urandom);
    send_word(ACT_POP,  $urandom);
    send_word(ACT_POP,  $urandom);
    send_word(ACT_POP,  $urandom);
    send_word(ACT_POP,  $urandom);

    // fill to the brim, then duplicate on full, push on full, drain past empty
    for (int i = 0; i < DEPTH; i++) send_word(ACT_PUSH, $urandom);
    send_word(ACT_PUSH, recent[recent.size() - 1]);
    send_word(ACT_PUSH, $urandom);
    for (int i = 0; i < DEPTH + 2; i++) send_word(ACT_POP, $urandom);

    // random phases that lean toward filling, draining or neither
    done = 0;
    while (done < RANDOM_ITEMS) begin
      mode     = $urandom_range(0, 2);
      len      = $urandom_range(100, 300);
      push_pct = (mode == 0) ? 90 : (mode == 1) ? 12 : 50;
      for (int k = 0; k < len && done < RANDOM_ITEMS; k++) begin
        calm = (done >= 700 && done < 1000);
        if ($urandom_range(0, 99) < push_pct) send_word(ACT_PUSH, pick_value());
        else send_word(ACT_POP, $urandom);
        done++;
      end
    end
    item_valid <= 1'b0;
    calm = 1'b0;

    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
